@@ rtl/assert_macros.svh @@
// Assertion macros shared by the LED PWM animation engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LPAE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpae assertion failed");
`define LPAE_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lpae forbidden condition seen");
`else
`define LPAE_ASSERT(lbl, clk, rst, prop)
`define LPAE_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ rtl/lpae_pkg.sv @@
// Types, constants and helpers for the LED PWM animation engine.
`timescale 1ns / 1ps
`default_nettype none

package lpae_pkg;

   localparam int unsigned CHANNELS_DEF = 13;
   localparam int unsigned LED_W        = 16;
   localparam int unsigned LEVEL_W      = 8;
   localparam int unsigned TIMER_W      = 16;
   localparam int unsigned COUNT_W      = 13;
   localparam int unsigned SNAKE_LEN    = 13;
   localparam int unsigned MODE_W       = 2;
   localparam int unsigned CHAN_W       = 4;
   localparam int unsigned ANIM_W       = 2;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned CSR_ADDR_W   = 5;
   localparam int unsigned CSR_IDX_W    = 3;

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEXT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SNAKE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_PERIOD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_PEAK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LEVEL  = 3'd4;

   localparam logic [TIMER_W-1:0] SNAKE_PERIOD_RST = 16'h0FFF;
   localparam logic [TIMER_W-1:0] FADE_PERIOD_RST  = 16'h01FF;
   localparam logic [TIMER_W-1:0] COUNT_PERIOD_RST = 16'h0FFF;
   localparam logic [LEVEL_W-1:0] FADE_PEAK_RST    = 8'h2F;
   localparam logic [LEVEL_W-1:0] COUNT_LEVEL_RST  = 8'h03;

   localparam logic [LED_W-1:0] LED_ALL_ON = 16'hFFFF;

   typedef enum logic [ANIM_W-1:0] {
      PAT_SNAKE = 2'd0,
      PAT_FADE  = 2'd1,
      PAT_COUNT = 2'd2
   } anim_type;

   typedef struct packed {
      logic [TIMER_W-1:0] snake_period;
      logic [TIMER_W-1:0] fade_period;
      logic [TIMER_W-1:0] count_period;
      logic [LEVEL_W-1:0] fade_peak;
      logic [LEVEL_W-1:0] count_level;
   } cfg_type;

   typedef struct packed {
      logic               tick;
      logic               set;
      logic               next;
      logic [CHAN_W-1:0]  channel;
      logic [LEVEL_W-1:0] level;
   } op_type;

   // snake ring contents; entries past the table read as dark
   function automatic logic [LEVEL_W-1:0] snake_entry(input logic [4:0] idx);
      logic [LEVEL_W-1:0] val;
      case (idx)
         5'd0:            val = 8'd15;
         5'd1, 5'd2:      val = 8'd8;
         5'd3, 5'd4:      val = 8'd5;
         5'd5, 5'd6:      val = 8'd1;
         default:         val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lpae_if.sv @@
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface lpae_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpae_pkg::MODE_W-1:0]   mode;
   logic [lpae_pkg::CHAN_W-1:0]   channel;
   logic [lpae_pkg::LEVEL_W-1:0]  level;

   modport source (output valid, mode, channel, level, input ready);
   modport sink   (input valid, mode, channel, level, output ready);
endinterface

interface lpae_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpae_pkg::LED_W-1:0]    led_word;
   logic [lpae_pkg::ANIM_W-1:0]   anim_select;
   logic                          manual_on;

   modport source (output valid, led_word, anim_select, manual_on, input ready);
   modport sink   (input valid, led_word, anim_select, manual_on, output ready);
endinterface

`default_nettype wire

@@ rtl/lpae_csr.sv @@
// APB-style configuration register bank.
`timescale 1ns / 1ps
`default_nettype none

module lpae_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpae_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lpae_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lpae_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output lpae_pkg::cfg_type                   cfg
);

   lpae_pkg::cfg_type                 cfg_ff, cfg_in;
   logic [lpae_pkg::CSR_IDX_W-1:0]    idx;
   logic                              wr_en;

   assign idx        = csr_paddr[lpae_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            lpae_pkg::CSR_SNAKE_PERIOD:
               cfg_in.snake_period = csr_pwdata[lpae_pkg::TIMER_W-1:0];
            lpae_pkg::CSR_FADE_PERIOD:
               cfg_in.fade_period = csr_pwdata[lpae_pkg::TIMER_W-1:0];
            lpae_pkg::CSR_COUNT_PERIOD:
               cfg_in.count_period = csr_pwdata[lpae_pkg::TIMER_W-1:0];
            lpae_pkg::CSR_FADE_PEAK:
               cfg_in.fade_peak = csr_pwdata[lpae_pkg::LEVEL_W-1:0];
            lpae_pkg::CSR_COUNT_LEVEL:
               cfg_in.count_level = csr_pwdata[lpae_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         lpae_pkg::CSR_SNAKE_PERIOD:
            csr_prdata = lpae_pkg::CSR_DATA_W'(cfg_ff.snake_period);
         lpae_pkg::CSR_FADE_PERIOD:
            csr_prdata = lpae_pkg::CSR_DATA_W'(cfg_ff.fade_period);
         lpae_pkg::CSR_COUNT_PERIOD:
            csr_prdata = lpae_pkg::CSR_DATA_W'(cfg_ff.count_period);
         lpae_pkg::CSR_FADE_PEAK:
            csr_prdata = lpae_pkg::CSR_DATA_W'(cfg_ff.fade_peak);
         lpae_pkg::CSR_COUNT_LEVEL:
            csr_prdata = lpae_pkg::CSR_DATA_W'(cfg_ff.count_level);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.snake_period <= lpae_pkg::SNAKE_PERIOD_RST;
         cfg_ff.fade_period  <= lpae_pkg::FADE_PERIOD_RST;
         cfg_ff.count_period <= lpae_pkg::COUNT_PERIOD_RST;
         cfg_ff.fade_peak    <= lpae_pkg::FADE_PEAK_RST;
         cfg_ff.count_level  <= lpae_pkg::COUNT_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lpae_anim.sv @@
// Animation generator: step timer, snake, fade and binary count patterns.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpae_anim #(
   parameter int unsigned CHANNELS = lpae_pkg::CHANNELS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  lpae_pkg::op_type                            op,
   input  lpae_pkg::cfg_type                           cfg,
   output logic                                        load_en,
   output logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0]  load_levels,
   output logic [lpae_pkg::ANIM_W-1:0]                 anim_sel,
   output logic                                        manual_on
);

   localparam int unsigned PW = $clog2(CHANNELS + 1);
   localparam int unsigned TW = $clog2(2 * CHANNELS);
   localparam logic [PW-1:0] POS_LAST = PW'(CHANNELS);
   localparam logic [TW-1:0] T_LAST   = TW'(CHANNELS);
   localparam logic [TW-1:0] T_WRAP   = TW'(CHANNELS + 1);

   lpae_pkg::anim_type                  anim_ff, anim_in;
   logic                                manual_ff, manual_in;
   logic [lpae_pkg::TIMER_W-1:0]        timer_ff, timer_in, timer_inc;
   logic [PW-1:0]                       pos_ff, pos_in;
   logic [lpae_pkg::LEVEL_W-1:0]        fade_ff, fade_in, fade_inc, fade_dec;
   logic                                falling_ff, falling_in;
   logic [lpae_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                period_hit, step;

   logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0] snake_lv, fade_lv, count_lv;

   assign timer_inc = timer_ff + 1'b1;
   assign fade_inc  = fade_ff + 1'b1;
   assign fade_dec  = fade_ff - 1'b1;

   always_comb begin
      case (anim_ff)
         lpae_pkg::PAT_SNAKE: period_hit = (timer_inc == cfg.snake_period);
         lpae_pkg::PAT_FADE:  period_hit = (timer_inc == cfg.fade_period);
         lpae_pkg::PAT_COUNT: period_hit = (timer_inc == cfg.count_period);
         default:             period_hit = 1'b0;
      endcase
   end

   assign step = op.tick & ~manual_ff & period_hit;

   // one lane per channel
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic [TW-1:0] t_raw, t_ring;
      assign t_raw  = TW'(pos_ff) + TW'(i);
      assign t_ring = (t_raw > T_LAST) ? (t_raw - T_WRAP) : t_raw;
      assign snake_lv[i] = lpae_pkg::snake_entry(5'(t_ring));
      assign fade_lv[i]  = fade_ff;
      if (i < lpae_pkg::COUNT_W) begin : g_cnt
         assign count_lv[i] = count_ff[i] ? cfg.count_level : '0;
      end else begin : g_dark
         assign count_lv[i] = '0;
      end
   end

   always_comb begin
      case (anim_ff)
         lpae_pkg::PAT_FADE:  load_levels = fade_lv;
         lpae_pkg::PAT_COUNT: load_levels = count_lv;
         default:             load_levels = snake_lv;
      endcase
   end

   assign load_en   = step;
   assign anim_sel  = anim_ff;
   assign manual_on = manual_ff;

   always_comb begin
      anim_in    = anim_ff;
      manual_in  = manual_ff;
      timer_in   = timer_ff;
      pos_in     = pos_ff;
      fade_in    = fade_ff;
      falling_in = falling_ff;
      count_in   = count_ff;
      if (op.tick && !manual_ff) begin
         timer_in = step ? '0 : timer_inc;
         if (step) begin
            case (anim_ff)
               lpae_pkg::PAT_SNAKE: begin
                  pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
               end
               lpae_pkg::PAT_FADE: begin
                  if (!falling_ff) begin
                     fade_in = fade_inc;
                     if (fade_inc == cfg.fade_peak) falling_in = 1'b1;
                  end else begin
                     fade_in = fade_dec;
                     if (fade_dec == '0) falling_in = 1'b0;
                  end
               end
               lpae_pkg::PAT_COUNT: begin
                  count_in = count_ff + 1'b1;
               end
               default: ;
            endcase
         end
      end
      if (op.set) manual_in = 1'b1;
      if (op.next) begin
         manual_in = 1'b0;
         case (anim_ff)
            lpae_pkg::PAT_SNAKE: begin
               anim_in    = lpae_pkg::PAT_FADE;
               fade_in    = '0;
               falling_in = 1'b0;
            end
            lpae_pkg::PAT_FADE: begin
               anim_in  = lpae_pkg::PAT_COUNT;
               count_in = '0;
            end
            default: begin
               anim_in = lpae_pkg::PAT_SNAKE;
               pos_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_ff    <= lpae_pkg::PAT_SNAKE;
         manual_ff  <= 1'b0;
         timer_ff   <= '0;
         pos_ff     <= '0;
         fade_ff    <= '0;
         falling_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         anim_ff    <= anim_in;
         manual_ff  <= manual_in;
         timer_ff   <= timer_in;
         pos_ff     <= pos_in;
         fade_ff    <= fade_in;
         falling_ff <= falling_in;
         count_ff   <= count_in;
      end
   end

   `LPAE_ASSERT(a_step_clears_timer, clock, reset, step |=> (timer_ff == '0))
   `LPAE_ASSERT(a_manual_freezes_timer, clock, reset, manual_ff |=> $stable(timer_ff))
   `LPAE_NEVER(a_snake_pos_range, clock, reset, pos_ff > POS_LAST)

endmodule

`default_nettype wire

@@ rtl/lpae_pwm.sv @@
// PWM core: pending and active levels, phase counter and LED word compare.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpae_pwm #(
   parameter int unsigned CHANNELS = lpae_pkg::CHANNELS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  lpae_pkg::op_type                            op,
   input  logic                                        load_en,
   input  logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0]  load_levels,
   output logic [lpae_pkg::LED_W-1:0]                  led_next
);

   logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0] pend_ff, pend_in;
   logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0] act_ff, act_in;
   logic [lpae_pkg::LEVEL_W-1:0]               phase_ff, phase_in;
   logic [lpae_pkg::LED_W-1:0]                 led_ff, led_in, led_base;
   logic                                       wrap;

   assign wrap     = (phase_ff == '0);
   assign act_in   = (op.tick && wrap) ? pend_ff : act_ff;
   assign led_base = wrap ? lpae_pkg::LED_ALL_ON : led_ff;
   assign phase_in = op.tick ? phase_ff + 1'b1 : phase_ff;

   always_comb begin
      led_next = led_base;
      for (int i = 0; i < CHANNELS; i++) begin
         if (act_in[i] == phase_ff) led_next[i] = 1'b0;
      end
   end

   assign led_in = op.tick ? led_next : led_ff;

   always_comb begin
      pend_in = pend_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         if (op.set && (5'(op.channel) == 5'(i))) pend_in[i] = op.level;
      end
      if (op.next) pend_in = '0;
      if (load_en) pend_in = load_levels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         act_ff   <= '0;
         phase_ff <= '0;
         led_ff   <= '0;
      end else begin
         pend_ff  <= pend_in;
         act_ff   <= act_in;
         phase_ff <= phase_in;
         led_ff   <= led_in;
      end
   end

   `LPAE_ASSERT(a_phase_only_on_tick, clock, reset, !op.tick |=> $stable(phase_ff))

endmodule

`default_nettype wire

@@ rtl/led_pwm_animation_engine.sv @@
// Top level of the LED PWM animation engine.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one request beat per clock unless a tick waits in the input
// register on a stalled response. Beats are worked from that register by
// the PWM compare (one comparator per channel against the phase) and the
// animation step logic; a tick's response beat is registered onto rsp.
// Set and next change state and give no response; the unused mode does
// neither. A stalled response holds only tick beats behind it. Registers
// sit at APB byte address 4*i (snake_period, fade_period, count_period,
// fade_peak, count_level); write them only while the engine is idle.
module led_pwm_animation_engine #(
   parameter int unsigned CHANNELS = lpae_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   lpae_req_if.sink                            req_bus,
   lpae_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpae_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lpae_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lpae_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   lpae_pkg::cfg_type                               cfg;
   lpae_pkg::op_type                                op;
   logic                                            load_en;
   logic [CHANNELS-1:0][lpae_pkg::LEVEL_W-1:0]      load_levels;
   logic [lpae_pkg::LED_W-1:0]                      led_next;
   logic [lpae_pkg::ANIM_W-1:0]                     anim_sel;
   logic                                            manual_on;

   logic                                in_valid_ff, in_valid_in;
   logic [lpae_pkg::MODE_W-1:0]         in_mode_ff;
   logic [lpae_pkg::CHAN_W-1:0]         in_chan_ff;
   logic [lpae_pkg::LEVEL_W-1:0]        in_level_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lpae_pkg::LED_W-1:0]          rsp_led_ff;
   logic [lpae_pkg::ANIM_W-1:0]         rsp_anim_ff;
   logic                                rsp_manual_ff;
   logic                                out_free, advance, req_take, in_held;

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign advance  = in_valid_ff & ((in_mode_ff != lpae_pkg::MODE_TICK) | out_free);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_take = req_bus.valid & req_bus.ready;
   assign in_held  = in_valid_ff & ~advance;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);

   assign op.tick    = advance & (in_mode_ff == lpae_pkg::MODE_TICK);
   assign op.set     = advance & (in_mode_ff == lpae_pkg::MODE_SET);
   assign op.next    = advance & (in_mode_ff == lpae_pkg::MODE_NEXT);
   assign op.channel = in_chan_ff;
   assign op.level   = in_level_ff;

   assign rsp_valid_in = op.tick | (rsp_valid_ff & ~rsp_bus.ready);

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.led_word    = rsp_led_ff;
   assign rsp_bus.anim_select = rsp_anim_ff;
   assign rsp_bus.manual_on   = rsp_manual_ff;

   lpae_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpae_anim #(.CHANNELS(CHANNELS)) u_anim (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .cfg         (cfg),
      .load_en     (load_en),
      .load_levels (load_levels),
      .anim_sel    (anim_sel),
      .manual_on   (manual_on)
   );

   lpae_pwm #(.CHANNELS(CHANNELS)) u_pwm (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .load_en     (load_en),
      .load_levels (load_levels),
      .led_next    (led_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_mode_ff  <= req_bus.mode;
         in_chan_ff  <= req_bus.channel;
         in_level_ff <= req_bus.level;
      end
      if (op.tick) begin
         rsp_led_ff    <= led_next;
         rsp_anim_ff   <= anim_sel;
         rsp_manual_ff <= manual_on;
      end
   end

   `LPAE_NEVER(a_no_rsp_overwrite, clock, reset, op.tick && rsp_valid_ff && !rsp_bus.ready)
   `LPAE_ASSERT(a_held_beat_kept, clock, reset, in_held |=> (in_valid_ff && $stable(in_mode_ff)))

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the LED PWM animation engine against a behavioural predictor.
`timescale 1ns / 1ps

module tb_top;
   import lpae_pkg::*;

   localparam int NCH = CHANNELS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES = 8;
   localparam int PHASE_BEATS = 100;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [LEVEL_W-1:0] SNAKE_SHAPE [0:SNAKE_LEN-1] =
      '{8'd15, 8'd8, 8'd8, 8'd5, 8'd5, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

   typedef struct packed {
      logic [LED_W-1:0] led_word;
      anim_type         anim;
      logic             manual;
   } led_beat_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAN_W-1:0]  channel;
      logic [LEVEL_W-1:0] level;
      logic               fixed;
      logic [LED_W-1:0]   led_word;
      anim_type           anim;
      logic               manual;
   } probe_row_type;

   localparam int PROBE_ROWS = 22;
   localparam probe_row_type PROBES [0:PROBE_ROWS-1] = '{
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd15, 8'd255, 1'b1, 16'hE000, PAT_SNAKE, 1'b0},
      '{MODE_UNUSED, 4'd15, 8'd255, 1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_UNUSED, 4'd0,  8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd0,  8'd255, 1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd15, 8'hAA,  1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd13, 8'd1,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd12, 8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_SNAKE, 1'b1},
      '{MODE_NEXT,   4'd0,  8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_FADE,  1'b0},
      '{MODE_TICK,   4'd5,  8'd85,  1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_NEXT,   4'd15, 8'd255, 1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_COUNT, 1'b0},
      '{MODE_NEXT,   4'd0,  8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b1, 16'hE000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd7,  8'd128, 1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_SET,    4'd3,  8'd1,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd10, 8'd170, 1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_NEXT,   4'd0,  8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0},
      '{MODE_TICK,   4'd0,  8'd0,   1'b0, 16'h0000, PAT_SNAKE, 1'b0}
   };

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lpae_req_if req_chan ();
   lpae_rsp_if rsp_chan ();

   led_pwm_animation_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_chan),
      .rsp_bus     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   cfg_type            engine_cfg;
   logic [LEVEL_W-1:0] lvl_pending [NCH];
   logic [LEVEL_W-1:0] lvl_active [NCH];
   logic [LEVEL_W-1:0] phase_ctr;
   logic [LED_W-1:0]   led_shadow;
   logic               manual_mode;
   anim_type           anim_now;
   logic [TIMER_W-1:0] step_ctr;
   logic [3:0]         snake_idx;
   logic [LEVEL_W-1:0] fade_lvl;
   logic               fade_down;
   logic [COUNT_W-1:0] count_ctr;

   led_beat_type led_beats [$];
   int        faults = 0;
   int        send_gap_pct = 0;
   int        recv_stall_pct = 0;
   int        quiet_cycles = 0;

   function automatic logic [CHAN_W-1:0] any_channel();
      return CHAN_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [LEVEL_W-1:0] any_level();
      return LEVEL_W'($urandom_range(0, 255));
   endfunction

   function automatic void predict_led_beat(input logic [MODE_W-1:0] m,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic [LEVEL_W-1:0] lv,
                                            output bit gives, output led_beat_type beat);
      int i;
      int t;
      gives = 1'b0;
      beat = '0;
      case (m)
         MODE_TICK: begin
            if (phase_ctr == 8'd0) begin
               for (i = 0; i < NCH; i++) lvl_active[i] = lvl_pending[i];
               led_shadow = LED_ALL_ON;
            end
            for (i = 0; i < NCH; i++)
               if (lvl_active[i] == phase_ctr) led_shadow[i] = 1'b0;
            phase_ctr = phase_ctr + 8'd1;
            if (!manual_mode) begin
               step_ctr = step_ctr + 16'd1;
               case (anim_now)
                  PAT_SNAKE: begin
                     if (step_ctr == engine_cfg.snake_period) begin
                        step_ctr = '0;
                        for (i = 0; i < NCH; i++) begin
                           t = int'(snake_idx) + i;
                           if (t > NCH) t -= NCH + 1;
                           lvl_pending[i] = (t < SNAKE_LEN) ? SNAKE_SHAPE[t] : 8'd0;
                        end
                        snake_idx = (snake_idx >= NCH) ? 4'd0 : snake_idx + 4'd1;
                     end
                  end
                  PAT_FADE: begin
                     if (step_ctr == engine_cfg.fade_period) begin
                        step_ctr = '0;
                        for (i = 0; i < NCH; i++) lvl_pending[i] = fade_lvl;
                        if (!fade_down) begin
                           fade_lvl = fade_lvl + 8'd1;
                           if (fade_lvl == engine_cfg.fade_peak) fade_down = 1'b1;
                        end else begin
                           fade_lvl = fade_lvl - 8'd1;
                           if (fade_lvl == 8'd0) fade_down = 1'b0;
                        end
                     end
                  end
                  PAT_COUNT: begin
                     if (step_ctr == engine_cfg.count_period) begin
                        step_ctr = '0;
                        for (i = 0; i < NCH; i++)
                           lvl_pending[i] = (i < COUNT_W && count_ctr[i]) ?
                                            engine_cfg.count_level : 8'd0;
                        count_ctr = count_ctr + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            gives = 1'b1;
            beat.led_word = led_shadow;
            beat.anim = anim_now;
            beat.manual = manual_mode;
         end
         MODE_SET: begin
            manual_mode = 1'b1;
            if (ch < NCH) lvl_pending[ch] = lv;
         end
         MODE_NEXT: begin
            manual_mode = 1'b0;
            for (i = 0; i < NCH; i++) lvl_pending[i] = 8'd0;
            case (anim_now)
               PAT_SNAKE: begin
                  anim_now = PAT_FADE;
                  fade_lvl = 8'd0;
                  fade_down = 1'b0;
               end
               PAT_FADE: begin
                  anim_now = PAT_COUNT;
                  count_ctr = '0;
               end
               default: begin
                  anim_now = PAT_SNAKE;
                  snake_idx = 4'd0;
               end
            endcase
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input logic [MODE_W-1:0] m, input logic [CHAN_W-1:0] ch,
                            input logic [LEVEL_W-1:0] lv, input bit fixed = 1'b0,
                            input led_beat_type fixed_beat = '0);
      bit           gives;
      led_beat_type beat;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= m;
      req_chan.channel <= ch;
      req_chan.level   <= lv;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_led_beat(m, ch, lv, gives, beat);
      if (gives) led_beats.push_back(fixed ? fixed_beat : beat);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         CSR_SNAKE_PERIOD: engine_cfg.snake_period = value[TIMER_W-1:0];
         CSR_FADE_PERIOD:  engine_cfg.fade_period  = value[TIMER_W-1:0];
         CSR_COUNT_PERIOD: engine_cfg.count_period = value[TIMER_W-1:0];
         CSR_FADE_PEAK:    engine_cfg.fade_peak    = value[LEVEL_W-1:0];
         CSR_COUNT_LEVEL:  engine_cfg.count_level  = value[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_engine(input cfg_type c);
      csr_write(CSR_SNAKE_PERIOD, {16'd0, c.snake_period});
      csr_write(CSR_FADE_PERIOD,  {16'd0, c.fade_period});
      csr_write(CSR_COUNT_PERIOD, {16'd0, c.count_period});
      csr_write(CSR_FADE_PEAK,    {24'd0, c.fade_peak});
      csr_write(CSR_COUNT_LEVEL,  {24'd0, c.count_level});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // tick runs let the patterns step; manual runs are sets, ticks, then mostly a next
   task automatic run_traffic(input int quota);
      int sent;
      int kind;
      int n;
      int i;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            n = $urandom_range(1, 48);
            for (i = 0; i < n; i++)
               send_beat(MODE_TICK, any_channel(), any_level());
            sent += n;
         end else if (kind < 82) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               send_beat(MODE_SET, any_channel(), any_level());
            sent += n;
            n = $urandom_range(1, 30);
            for (i = 0; i < n; i++)
               send_beat(MODE_TICK, any_channel(), any_level());
            sent += n;
            if ($urandom_range(0, 9) < 7) begin
               send_beat(MODE_NEXT, any_channel(), any_level());
               sent++;
            end
         end else if (kind < 94) begin
            send_beat(MODE_NEXT, any_channel(), any_level());
            sent++;
         end else begin
            send_beat(MODE_UNUSED, any_channel(), any_level());
            sent++;
         end
      end
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (led_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : led_word_check
      led_beat_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (led_beats.size() == 0) begin
               $error("unexpected beat: led_word %h", rsp_chan.led_word);
               faults++;
            end else begin
               want = led_beats.pop_front();
               if (rsp_chan.led_word !== want.led_word) begin
                  $error("led_word: expected %h, got %h", want.led_word, rsp_chan.led_word);
                  faults++;
               end
               if (rsp_chan.anim_select !== want.anim) begin
                  $error("anim_select: expected %0d, got %0d", want.anim, rsp_chan.anim_select);
                  faults++;
               end
               if (rsp_chan.manual_on !== want.manual) begin
                  $error("manual_on: expected %0d, got %0d", want.manual, rsp_chan.manual_on);
                  faults++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int           ph;
      int           r;
      int           per;
      cfg_type      cfg;
      led_beat_type fixed_beat;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_TICK;
      req_chan.channel = '0;
      req_chan.level = '0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      engine_cfg = '{SNAKE_PERIOD_RST, FADE_PERIOD_RST, COUNT_PERIOD_RST,
                     FADE_PEAK_RST, COUNT_LEVEL_RST};
      for (r = 0; r < NCH; r++) begin
         lvl_pending[r] = '0;
         lvl_active[r] = '0;
      end
      phase_ctr = '0;
      led_shadow = '0;
      manual_mode = 1'b0;
      anim_now = PAT_SNAKE;
      step_ctr = '0;
      snake_idx = '0;
      fade_lvl = '0;
      fade_down = 1'b0;
      count_ctr = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < PHASES; ph++) begin
         send_gap_pct = (ph < 3) ? 36 : (ph < 6) ? 81 : 0;
         recv_stall_pct = (ph < 3) ? 81 : (ph < 6) ? 36 : 0;
         if (ph == 0) begin
            cfg = '{16'd1, 16'd1, 16'd1, 8'd255, 8'd255};
         end else if (ph == PHASES - 1) begin
            cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 8'd0};
         end else if (ph == PHASES - 2) begin
            // per-pattern periods are drawn independently; a switch may leave the timer past its period
            cfg.snake_period = TIMER_W'($urandom_range(1, 8));
            cfg.fade_period = TIMER_W'($urandom_range(1, 8));
            cfg.count_period = TIMER_W'($urandom_range(1, 8));
            cfg.fade_peak = LEVEL_W'($urandom_range(1, 255));
            cfg.count_level = LEVEL_W'($urandom_range(0, 255));
         end else begin
            // shared period kept above the timer so the patterns keep stepping
            per = $urandom_range(1, 8);
            if (per <= int'(step_ctr)) per = int'(step_ctr) + 1;
            cfg.snake_period = TIMER_W'(per);
            cfg.fade_period = TIMER_W'(per);
            cfg.count_period = TIMER_W'(per);
            cfg.fade_peak = LEVEL_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 6) :
                                                                    $urandom_range(1, 255));
            cfg.count_level = LEVEL_W'($urandom_range(0, 255));
         end
         program_engine(cfg);
         if (ph == 0) begin
            for (r = 0; r < PROBE_ROWS; r++) begin
               fixed_beat = '{PROBES[r].led_word, PROBES[r].anim, PROBES[r].manual};
               send_beat(PROBES[r].mode, PROBES[r].channel, PROBES[r].level,
                         PROBES[r].fixed, fixed_beat);
            end
         end
         run_traffic(PHASE_BEATS);
         drain();
      end

      if (faults == 0 && led_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
